>>> rtl/core/tma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_pkg: shared types and constants
// Reset values, register indexes and the divider request/response structs.
// ----------------------------------------------------------------------------
package tma_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned TpmsW = 23;

	localparam logic [DataW-1:0] TpsReset     = 32'd12500000;
	localparam logic [TpmsW-1:0] TpmsReset    = 23'd12500;
	localparam logic [DataW-1:0] MsPerSecond  = 32'd1000;

	typedef enum logic {
		REG_TICKS_PER_SECOND = 1'b0,
		REG_TICKS_PER_MS     = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic             start;
		logic [DataW-1:0] dividend;
		logic [DataW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DataW-1:0] quotient;
		logic [DataW-1:0] remainder;
	} div_rsp_t;

endpackage

>>> rtl/core/tma_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_divider: shared restoring divider
// One compare and subtract per cycle, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tma_divider
	import tma_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int unsigned CntW = $clog2(DataW);

	logic [DataW-1:0] rem_q;
	logic [DataW-1:0] quo_q;
	logic [DataW-1:0] div_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DataW:0]   trial;
	logic [DataW:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DataW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= req.dividend;
				div_q  <= req.divisor;
			end else if (busy_q) begin
				// The partial remainder stays below the divisor, so 32 bits hold it.
				rem_q <= ge ? diff[DataW-1:0] : trial[DataW-1:0];
				quo_q <= {quo_q[DataW-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DataW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q)
		else $error("divider done while still busy");
`endif

endmodule

>>> rtl/core/tick_to_millisecond_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_to_millisecond_accumulator: wrap-safe counter reading to milliseconds
// Accumulates counter deltas and folds whole seconds and milliseconds into a
// wrapping millisecond total with one shared iterative divider.
//
//   channel   dir   fields (lsb up)           transfer when
//   s_axis    in    counter_reading[31:0]     s_axis_tvalid && s_axis_tready
//   m_axis    out   elapsed_ms[31:0]          m_axis_tvalid && m_axis_tready
//   cfg       in    cfg_addr, cfg_wdata       cfg_we
//
// An item goes from its transfer through up to two divider passes (seconds,
// then milliseconds), each a start state and a run state that retires on done,
// and then an emit state that loads the output register. A zero step skips its pass.
// The input is ready again once the emit state has handed its result over.
// The input is not ready while an item is in work; a stalled result sits in
// the output register and the next item may be taken meanwhile.
// Reset clears all state and restores the reset step values.
// ----------------------------------------------------------------------------
module tick_to_millisecond_accumulator
	import tma_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [DataW-1:0] s_axis_tdata,   // counter_reading[31:0]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [DataW-1:0] m_axis_tdata,   // elapsed_ms[31:0]
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [DataW-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COARSE_GO,
		ST_COARSE_RUN,
		ST_FINE_GO,
		ST_FINE_RUN,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [DataW-1:0] tps_q;
	logic [TpmsW-1:0] tpms_q;
	logic [DataW-1:0] prev_q;
	logic [DataW-1:0] rem_q;
	logic [DataW-1:0] ms_total_q;
	logic             out_valid_q;
	logic [DataW-1:0] out_data_q;

	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic [DataW-1:0] rem_sum;
	logic             accept;
	logic             emit;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign rem_sum       = rem_q + (s_axis_tdata - prev_q);
	assign emit          = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	always_comb begin
		div_req.start    = (state_q == ST_COARSE_GO) || (state_q == ST_FINE_GO);
		div_req.dividend = rem_q;
		div_req.divisor  = (state_q == ST_COARSE_GO) ? tps_q : DataW'(tpms_q);
	end

	tma_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q  <= TpsReset;
			tpms_q <= TpmsReset;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_addr))
				REG_TICKS_PER_SECOND: tps_q  <= cfg_wdata;
				REG_TICKS_PER_MS:     tpms_q <= cfg_wdata[TpmsW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			rem_q       <= '0;
			ms_total_q  <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				out_data_q  <= ms_total_q;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rem_q  <= rem_sum;
						prev_q <= s_axis_tdata;
						if (tps_q != '0) begin
							state_q <= ST_COARSE_GO;
						end else if (tpms_q != '0) begin
							state_q <= ST_FINE_GO;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_COARSE_GO: state_q <= ST_COARSE_RUN;
				ST_COARSE_RUN: begin
					if (div_rsp.done) begin
						rem_q      <= div_rsp.remainder;
						ms_total_q <= ms_total_q + DataW'(div_rsp.quotient * MsPerSecond);
						state_q    <= (tpms_q != '0) ? ST_FINE_GO : ST_EMIT;
					end
				end
				ST_FINE_GO: state_q <= ST_FINE_RUN;
				ST_FINE_RUN: begin
					if (div_rsp.done) begin
						rem_q      <= div_rsp.remainder;
						ms_total_q <= ms_total_q + div_rsp.quotient;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// Wait until the previous result has been taken.
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input ready right after a transfer");
	a_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> !div_req.start)
		else $error("divider started while busy");
	a_result_is_total: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> (m_axis_tdata == ms_total_q))
		else $error("result differs from the millisecond total");
	a_idle_divider: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_rsp.busy)
		else $error("divider running while idle");
`endif

endmodule
